### design/mfpa_pkg.sv
// Shared types and constants of the max-flow path augmenter.
// Used by mfpa_edge_mem and max_flow_path_augmenter; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mfpa_pkg;

  // Fixed field widths of the request and result channels.
  localparam int unsigned NODE_W  = 3;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned TOTAL_W = 19;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 19'h7FFFF;

  // Request opcodes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_PATH  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Result kinds.
  localparam logic KIND_PATH = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Path result status codes.
  localparam logic [1:0] STAT_APPLIED  = 2'd0;
  localparam logic [1:0] STAT_REJECTED = 2'd1;
  localparam logic [1:0] STAT_TOO_LONG = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN_FIRST,
    ST_SCAN_NODE0,
    ST_SCAN_ADDR,
    ST_SCAN_CHECK,
    ST_APPLY_FIRST,
    ST_APPLY_NODE0,
    ST_FWD_READ,
    ST_FWD_WRITE,
    ST_REV_READ,
    ST_REV_WRITE,
    ST_TOTAL,
    ST_EMIT
  } state_t;

  // Write enables of the edge memories.
  typedef struct packed {
    logic cap_we;
    logic res_we;
  } mem_wr_t;

endpackage

`default_nettype wire

### design/max_flow_path_augmenter.sv
// Top level of the max-flow path augmenter: sequencer, path buffer and flow total.
// Depends on mfpa_pkg and mfpa_edge_mem.
//
//   channel | ports                                   | direction
//   in_     | valid/ready, opcode, nodes, value, last | request into the block
//   out_    | valid/ready, kind, status, theta, flows | result out of the block
//
// Writes, non-final path nodes and unused opcodes finish in the idle state. A final
// node walks the path twice through the single residual memory port, checking each
// edge in scan-address and check states, then updating it in forward and reverse
// read and write states. After reset a clearing pass over all NODES*NODES entries
// zeroes the edge memories before the first request is taken. A stalled result
// holds the sequencer; requests are taken again once the result register is free.
`timescale 1ns / 1ps
`default_nettype none

module max_flow_path_augmenter #(
  parameter int unsigned NODES     = 8,
  parameter int unsigned CAP_WIDTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_opcode,
  input  wire  [2:0]  in_from_node,
  input  wire  [2:0]  in_to_node,
  input  wire  [15:0] in_capacity_value,
  input  wire         in_last_node,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_result_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_bottleneck,
  output logic [18:0] out_total_flow,
  output logic [15:0] out_edge_flow
);

  localparam int unsigned DEPTH = NODES * NODES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(NODES);
  localparam int unsigned LW    = $clog2(NODES + 2);
  localparam int unsigned RW    = CAP_WIDTH + 1;
  localparam int unsigned XW    = (RW > mfpa_pkg::VAL_W) ? RW : mfpa_pkg::VAL_W;
  localparam int unsigned SW    = ((RW > mfpa_pkg::TOTAL_W) ? RW : mfpa_pkg::TOTAL_W) + 1;
  localparam logic [RW-1:0] RES_MAX = {RW{1'b1}};
  localparam logic [RW-1:0] CAP_MAX = {1'b0, {CAP_WIDTH{1'b1}}};

  // Linear edge index of a (tail, head) pair.
  function automatic logic [AW-1:0] edge_addr(input logic [2:0] tail, input logic [2:0] head);
    logic [31:0] lin;
    lin = 32'(tail) * 32'(NODES) + 32'(head);
    return lin[AW-1:0];
  endfunction

  // A node index at or above NODES has no edges.
  function automatic logic node_ok(input logic [2:0] node);
    return (32'(node) < 32'(NODES));
  endfunction

  mfpa_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;
  logic [LW-1:0]  plen_r, plen_nxt;
  logic [LW-1:0]  k_r, k_nxt;
  logic [LW-1:0]  kp1;
  logic [LW-1:0]  len_in;
  logic [2:0]     prev_r, prev_nxt;
  logic [2:0]     cur_r, cur_nxt;
  logic [RW-1:0]  theta_r, theta_nxt;
  logic           kind_r, kind_nxt;
  logic [1:0]     status_r, status_nxt;
  logic [RW-1:0]  bneck_r, bneck_nxt;
  logic [CAP_WIDTH-1:0] flow_r, flow_nxt;
  logic           rd_ok_r, rd_ok_nxt;
  logic [mfpa_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic           load_out;

  logic [XW-1:0]  cap_ext;
  logic [CAP_WIDTH-1:0] cap_in;
  logic [2:0]     tail_sel, head_sel;
  logic [AW-1:0]  edge_a;
  mfpa_pkg::mem_wr_t mem_wr;
  logic [AW-1:0]  mem_addr;
  logic [CAP_WIDTH-1:0] cap_wdata;
  logic [RW-1:0]  res_wdata;
  logic [CAP_WIDTH-1:0] cap_q;
  logic [RW-1:0]  res_q;
  logic [RW:0]    res_sum;
  logic [RW-1:0]  res_sub;
  logic [SW-1:0]  total_sum;
  logic [RW:0]    cap_minus_res;

  logic [2:0]     pb_mem [NODES];
  logic [2:0]     pb_q;
  logic           pb_we;
  logic [PW-1:0]  pb_raddr;

  logic [XW-1:0]  bneck_ext;
  logic [XW-1:0]  flow_ext;

  assign cap_ext = XW'(in_capacity_value);
  assign cap_in  = cap_ext[CAP_WIDTH-1:0];
  assign kp1     = k_r + LW'(1);
  assign len_in  = (plen_r < LW'(NODES)) ? (plen_r + LW'(1)) : LW'(NODES + 1);

  // Shared edge address unit and shared residual arithmetic.
  // The clearing pass walks the memories with its own counter.
  assign edge_a        = edge_addr(tail_sel, head_sel);
  assign mem_addr      = (state_r == mfpa_pkg::ST_CLEAR) ? clr_r : edge_a;
  assign res_sum       = {1'b0, res_q} + {1'b0, theta_r};
  assign res_sub       = (res_q > theta_r) ? (res_q - theta_r) : '0;
  assign total_sum     = SW'(total_r) + SW'(theta_r);
  assign cap_minus_res = {2'b00, cap_q} - {1'b0, res_q};

  mfpa_edge_mem #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CAP_WIDTH)
  ) u_edge_mem (
    .clk      (clk),
    .wr       (mem_wr),
    .waddr    (mem_addr),
    .cap_wdata(cap_wdata),
    .res_wdata(res_wdata),
    .raddr    (mem_addr),
    .cap_rdata(cap_q),
    .res_rdata(res_q)
  );

  // Path buffer: written at the current length, read through a registered port.
  always_ff @(posedge clk) begin
    if (pb_we) begin
      pb_mem[plen_r[PW-1:0]] <= in_from_node;
    end
    pb_q <= pb_mem[pb_raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfpa_pkg::ST_CLEAR;
      clr_r   <= '0;
      plen_r  <= '0;
      k_r     <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      plen_r  <= plen_nxt;
      k_r     <= k_nxt;
      total_r <= total_nxt;
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    prev_r   <= prev_nxt;
    cur_r    <= cur_nxt;
    theta_r  <= theta_nxt;
    kind_r   <= kind_nxt;
    status_r <= status_nxt;
    bneck_r  <= bneck_nxt;
    flow_r   <= flow_nxt;
    rd_ok_r  <= rd_ok_nxt;
  end

  // Sequencer: next state, memory controls and result staging.
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    plen_nxt   = plen_r;
    k_nxt      = k_r;
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    theta_nxt  = theta_r;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    bneck_nxt  = bneck_r;
    flow_nxt   = flow_r;
    rd_ok_nxt  = rd_ok_r;
    total_nxt  = total_r;
    load_out   = 1'b0;
    in_ready   = 1'b0;
    tail_sel   = prev_r;
    head_sel   = cur_r;
    mem_wr     = '0;
    cap_wdata  = cap_in;
    res_wdata  = {1'b0, cap_in};
    pb_we      = 1'b0;
    pb_raddr   = '0;

    unique case (state_r)
      mfpa_pkg::ST_CLEAR: begin
        mem_wr.cap_we = 1'b1;
        mem_wr.res_we = 1'b1;
        cap_wdata     = '0;
        res_wdata     = '0;
        clr_nxt       = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = mfpa_pkg::ST_IDLE;
        end
      end

      mfpa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        tail_sel = in_from_node;
        head_sel = in_to_node;
        if (in_valid) begin
          unique case (in_opcode)
            mfpa_pkg::OP_WRITE: begin
              if (node_ok(in_from_node) && node_ok(in_to_node)) begin
                mem_wr.cap_we = 1'b1;
                mem_wr.res_we = 1'b1;
              end
            end
            mfpa_pkg::OP_READ: begin
              rd_ok_nxt = node_ok(in_from_node) && node_ok(in_to_node);
              state_nxt = mfpa_pkg::ST_READ;
            end
            mfpa_pkg::OP_PATH: begin
              pb_we    = (plen_r < LW'(NODES));
              plen_nxt = len_in;
              if (in_last_node) begin
                kind_nxt  = mfpa_pkg::KIND_PATH;
                bneck_nxt = '0;
                flow_nxt  = '0;
                if (len_in > LW'(NODES)) begin
                  status_nxt = mfpa_pkg::STAT_TOO_LONG;
                  plen_nxt   = '0;
                  state_nxt  = mfpa_pkg::ST_EMIT;
                end else if (len_in < LW'(2)) begin
                  status_nxt = mfpa_pkg::STAT_REJECTED;
                  plen_nxt   = '0;
                  state_nxt  = mfpa_pkg::ST_EMIT;
                end else begin
                  state_nxt = mfpa_pkg::ST_SCAN_FIRST;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      mfpa_pkg::ST_READ: begin
        kind_nxt   = mfpa_pkg::KIND_READ;
        status_nxt = mfpa_pkg::STAT_APPLIED;
        bneck_nxt  = '0;
        if (rd_ok_r && ({1'b0, cap_q} > res_q)) begin
          flow_nxt = cap_minus_res[CAP_WIDTH-1:0];
        end else begin
          flow_nxt = '0;
        end
        state_nxt = mfpa_pkg::ST_EMIT;
      end

      // First walk: every forward residual must be positive; track the minimum.
      mfpa_pkg::ST_SCAN_FIRST: begin
        pb_raddr  = '0;
        theta_nxt = RES_MAX;
        state_nxt = mfpa_pkg::ST_SCAN_NODE0;
      end

      mfpa_pkg::ST_SCAN_NODE0: begin
        prev_nxt  = pb_q;
        k_nxt     = LW'(1);
        pb_raddr  = PW'(1);
        state_nxt = mfpa_pkg::ST_SCAN_ADDR;
      end

      mfpa_pkg::ST_SCAN_ADDR: begin
        tail_sel = prev_r;
        head_sel = pb_q;
        cur_nxt  = pb_q;
        if (node_ok(prev_r) && node_ok(pb_q)) begin
          state_nxt = mfpa_pkg::ST_SCAN_CHECK;
        end else begin
          status_nxt = mfpa_pkg::STAT_REJECTED;
          plen_nxt   = '0;
          state_nxt  = mfpa_pkg::ST_EMIT;
        end
      end

      mfpa_pkg::ST_SCAN_CHECK: begin
        if (res_q == '0) begin
          status_nxt = mfpa_pkg::STAT_REJECTED;
          plen_nxt   = '0;
          state_nxt  = mfpa_pkg::ST_EMIT;
        end else begin
          if (res_q < theta_r) begin
            theta_nxt = res_q;
          end
          prev_nxt = cur_r;
          if (kp1 == plen_r) begin
            state_nxt = mfpa_pkg::ST_APPLY_FIRST;
          end else begin
            k_nxt     = kp1;
            pb_raddr  = kp1[PW-1:0];
            state_nxt = mfpa_pkg::ST_SCAN_ADDR;
          end
        end
      end

      // Second walk: lower each forward residual and raise its reverse.
      mfpa_pkg::ST_APPLY_FIRST: begin
        pb_raddr = '0;
        if (theta_r > CAP_MAX) begin
          theta_nxt = CAP_MAX;
        end
        state_nxt = mfpa_pkg::ST_APPLY_NODE0;
      end

      mfpa_pkg::ST_APPLY_NODE0: begin
        prev_nxt  = pb_q;
        k_nxt     = LW'(1);
        pb_raddr  = PW'(1);
        state_nxt = mfpa_pkg::ST_FWD_READ;
      end

      mfpa_pkg::ST_FWD_READ: begin
        tail_sel  = prev_r;
        head_sel  = pb_q;
        cur_nxt   = pb_q;
        state_nxt = mfpa_pkg::ST_FWD_WRITE;
      end

      mfpa_pkg::ST_FWD_WRITE: begin
        tail_sel      = prev_r;
        head_sel      = cur_r;
        mem_wr.res_we = 1'b1;
        res_wdata     = res_sub;
        state_nxt     = mfpa_pkg::ST_REV_READ;
      end

      mfpa_pkg::ST_REV_READ: begin
        tail_sel  = cur_r;
        head_sel  = prev_r;
        state_nxt = mfpa_pkg::ST_REV_WRITE;
      end

      mfpa_pkg::ST_REV_WRITE: begin
        tail_sel      = cur_r;
        head_sel      = prev_r;
        mem_wr.res_we = 1'b1;
        res_wdata     = res_sum[RW] ? RES_MAX : res_sum[RW-1:0];
        prev_nxt      = cur_r;
        if (kp1 == plen_r) begin
          state_nxt = mfpa_pkg::ST_TOTAL;
        end else begin
          k_nxt     = kp1;
          pb_raddr  = kp1[PW-1:0];
          state_nxt = mfpa_pkg::ST_FWD_READ;
        end
      end

      mfpa_pkg::ST_TOTAL: begin
        if (total_sum > SW'(mfpa_pkg::TOTAL_MAX)) begin
          total_nxt = mfpa_pkg::TOTAL_MAX;
        end else begin
          total_nxt = total_sum[mfpa_pkg::TOTAL_W-1:0];
        end
        kind_nxt   = mfpa_pkg::KIND_PATH;
        status_nxt = mfpa_pkg::STAT_APPLIED;
        bneck_nxt  = theta_r;
        flow_nxt   = '0;
        plen_nxt   = '0;
        state_nxt  = mfpa_pkg::ST_EMIT;
      end

      mfpa_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out  = 1'b1;
          state_nxt = mfpa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mfpa_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register.
  assign bneck_ext = XW'(bneck_r);
  assign flow_ext  = XW'(flow_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_result_kind <= kind_r;
      out_status      <= status_r;
      out_bottleneck  <= bneck_ext[15:0];
      out_total_flow  <= total_r;
      out_edge_flow   <= flow_ext[15:0];
    end
  end

  // No result can appear while the memories are being cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfpa_pkg::ST_CLEAR) |-> !out_valid)
    else $error("result present during clearing pass");

  // An applied path always carries a nonzero bottleneck.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfpa_pkg::ST_TOTAL) |-> (theta_r != '0))
    else $error("zero bottleneck reached the flow total");

  // The flow total only moves when an applied path is accounted.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mfpa_pkg::ST_TOTAL) |=> (total_r == $past(total_r)))
    else $error("flow total changed outside its update step");

endmodule

`default_nettype wire

### design/mfpa_edge_mem.sv
// Capacity and residual memories, one entry per directed edge.
// One shared write address and one shared read address; read data registered. Uses mfpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfpa_edge_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 16
) (
  input  wire                  clk,
  input  mfpa_pkg::mem_wr_t    wr,
  input  wire  [AW-1:0]        waddr,
  input  wire  [CW-1:0]        cap_wdata,
  input  wire  [CW:0]          res_wdata,
  input  wire  [AW-1:0]        raddr,
  output logic [CW-1:0]        cap_rdata,
  output logic [CW:0]          res_rdata
);

  logic [CW-1:0] cap_mem [DEPTH];
  logic [CW:0]   res_mem [DEPTH];

  // Capacity memory port.
  always_ff @(posedge clk) begin
    if (wr.cap_we) begin
      cap_mem[waddr] <= cap_wdata;
    end
    cap_rdata <= cap_mem[raddr];
  end

  // Residual memory port.
  always_ff @(posedge clk) begin
    if (wr.res_we) begin
      res_mem[waddr] <= res_wdata;
    end
    res_rdata <= res_mem[raddr];
  end

endmodule

`default_nettype wire
